[rtl/fpadd_pkg.sv]
// Shared types and constants for the single-precision adder pipeline.
// No dependencies; every other file in rtl/ refers to this package.
package fpadd_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
    localparam logic [4:0]  ALIGN_CAP = 5'd25;
    localparam logic [5:0]  TOP_POS   = 6'd50;
    localparam logic [8:0]  EXP_BIAS_ADJ = 9'd49;

    // Stage 1: operands unpacked and ordered by exponent.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic [7:0]  emax;
        logic [23:0] mmax;
        logic [23:0] mmin;
        logic [4:0]  align_sh;
        logic        smax;
        logic        smin;
    } unpack_t;

    // Stage 2: smaller significand aligned to the larger one.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic [7:0]  emax;
        logic [23:0] mmax;
        logic [48:0] small_al;
        logic        smax;
        logic        eff_sub;
    } align_t;

    // Stage 3: raw two's complement sum of the aligned significands.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic [7:0]  emax;
        logic        smax;
        logic [50:0] raw;
    } sum_t;

    // Stage 4: magnitude with its normalization shift and exponent.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic        zero;
        logic [7:0]  exp;
        logic [5:0]  shamt;
        logic [49:0] mag;
    } norm_t;

    // Per-stage advance enables from the pipeline control.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } stage_en_t;

endpackage

[rtl/fpadd_front.sv]
// Front end of the adder: operand decode, special cases, exponent ordering
// and significand alignment (pipeline stages 1 and 2). Uses fpadd_pkg.
module fpadd_front (
    input  logic                clk,
    input  logic                en1,
    input  logic                en2,
    input  logic [31:0]         operand_a,
    input  logic [31:0]         operand_b,
    output fpadd_pkg::align_t   align_q
);

    fpadd_pkg::unpack_t unpack_next;
    fpadd_pkg::unpack_t unpack_reg;
    fpadd_pkg::align_t  align_next;
    fpadd_pkg::align_t  align_reg;

    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [22:0] fa;
    logic [22:0] fb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        nan_a;
    logic        nan_b;
    logic        swap;
    logic [7:0]  ediff;
    logic [48:0] small_ext;

    // Decode, special operands and ordering by exponent.
    always_comb
    begin
        ea    = operand_a[30:23];
        eb    = operand_b[30:23];
        fa    = operand_a[22:0];
        fb    = operand_b[22:0];
        nan_a = (ea == 8'hFF) && (fa != 23'd0);
        nan_b = (eb == 8'hFF) && (fb != 23'd0);
        ma    = (ea != 8'd0) ? {1'b1, fa} : {fa, 1'b0};
        mb    = (eb != 8'd0) ? {1'b1, fb} : {fb, 1'b0};
        swap  = eb > ea;

        unpack_next.spec = (ea == 8'hFF) || (eb == 8'hFF);
        if (nan_a || nan_b)
        begin
            unpack_next.spec_val = fpadd_pkg::QNAN_BITS;
        end
        else if ((ea == 8'hFF) && (eb == 8'hFF) && (operand_a[31] != operand_b[31]))
        begin
            unpack_next.spec_val = fpadd_pkg::QNAN_BITS;
        end
        else if (ea == 8'hFF)
        begin
            unpack_next.spec_val = {operand_a[31], 31'd0} | fpadd_pkg::INF_BITS;
        end
        else
        begin
            unpack_next.spec_val = {operand_b[31], 31'd0} | fpadd_pkg::INF_BITS;
        end

        unpack_next.emax = swap ? eb : ea;
        unpack_next.mmax = swap ? mb : ma;
        unpack_next.mmin = swap ? ma : mb;
        unpack_next.smax = swap ? operand_b[31] : operand_a[31];
        unpack_next.smin = swap ? operand_a[31] : operand_b[31];
        ediff = swap ? (eb - ea) : (ea - eb);
        unpack_next.align_sh = (ediff > {3'd0, fpadd_pkg::ALIGN_CAP}) ?
                               fpadd_pkg::ALIGN_CAP : ediff[4:0];
    end

    // Alignment of the smaller significand against the larger one.
    always_comb
    begin
        small_ext            = {25'd0, unpack_reg.mmin};
        align_next.spec      = unpack_reg.spec;
        align_next.spec_val  = unpack_reg.spec_val;
        align_next.emax      = unpack_reg.emax;
        align_next.mmax      = unpack_reg.mmax;
        align_next.small_al  = small_ext << (fpadd_pkg::ALIGN_CAP - unpack_reg.align_sh);
        align_next.smax      = unpack_reg.smax;
        align_next.eff_sub   = unpack_reg.smax ^ unpack_reg.smin;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            unpack_reg <= unpack_next;
        end
        if (en2)
        begin
            align_reg <= align_next;
        end
    end

    assign align_q = align_reg;

endmodule

[rtl/fpadd_add.sv]
// Significand adder and normalization analysis (pipeline stages 3 and 4):
// signed add, magnitude, leading-one search and exponent. Uses fpadd_pkg.
module fpadd_add (
    input  logic                clk,
    input  logic                en3,
    input  logic                en4,
    input  fpadd_pkg::align_t   align_q,
    output fpadd_pkg::norm_t    norm_q
);

    fpadd_pkg::sum_t  sum_next;
    fpadd_pkg::sum_t  sum_reg;
    fpadd_pkg::norm_t norm_next;
    fpadd_pkg::norm_t norm_reg;

    logic [50:0] big_ext;
    logic [50:0] small_ext;
    logic [50:0] absval;
    logic [5:0]  top;
    logic [5:0]  lshift;
    logic [8:0]  limit;
    logic        subn;
    logic [8:0]  exp_wide;

    // Add or subtract the aligned significands.
    always_comb
    begin
        big_ext   = {2'b00, align_q.mmax, 25'd0};
        small_ext = {2'b00, align_q.small_al};
        sum_next.spec     = align_q.spec;
        sum_next.spec_val = align_q.spec_val;
        sum_next.emax     = align_q.emax;
        sum_next.smax     = align_q.smax;
        sum_next.raw      = align_q.eff_sub ? (big_ext - small_ext) : (big_ext + small_ext);
    end

    // Magnitude, leading-one position and normalization shift.
    always_comb
    begin
        absval = sum_reg.raw[50] ? (~sum_reg.raw + 51'd1) : sum_reg.raw;
        top    = 6'd0;
        for (int i = 0; i < 50; i++)
        begin
            if (absval[i])
            begin
                top = 6'(i);
            end
        end
        lshift   = fpadd_pkg::TOP_POS - top;
        limit    = {1'b0, sum_reg.emax} + 9'd1;
        subn     = {3'd0, lshift} > limit;
        exp_wide = {1'b0, sum_reg.emax} + {3'd0, top} - fpadd_pkg::EXP_BIAS_ADJ;

        norm_next.spec     = sum_reg.spec;
        norm_next.spec_val = sum_reg.spec_val;
        norm_next.sign     = sum_reg.smax ^ sum_reg.raw[50];
        norm_next.zero     = (absval == 51'd0);
        norm_next.exp      = subn ? 8'd0 : exp_wide[7:0];
        norm_next.shamt    = subn ? limit[5:0] : lshift;
        norm_next.mag      = absval[49:0];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sum_reg <= sum_next;
        end
        if (en4)
        begin
            norm_reg <= norm_next;
        end
    end

    assign norm_q = norm_reg;

endmodule

[rtl/fpadd_round.sv]
// Final stage: normalizing shift, round to nearest even, overflow
// saturation and result selection (pipeline stage 5). Uses fpadd_pkg.
module fpadd_round (
    input  logic               clk,
    input  logic               en5,
    input  fpadd_pkg::norm_t   norm_q,
    output logic [31:0]        sum_bits
);

    logic [50:0] shifted;
    logic        guard;
    logic        sticky;
    logic        lsb;
    logic [24:0] rounded;
    logic [31:0] total;
    logic [31:0] sum_next;
    logic [31:0] sum_reg;

    // Normalize, round and pack.
    always_comb
    begin
        shifted = {1'b0, norm_q.mag} << norm_q.shamt;
        guard   = shifted[26];
        sticky  = shifted[25:0] != 26'd0;
        lsb     = shifted[27];
        rounded = {1'b0, shifted[50:27]} + {24'd0, guard && (sticky || lsb)};
        total   = {1'b0, norm_q.exp, 23'd0} + {7'd0, rounded};
        if (total >= fpadd_pkg::INF_BITS)
        begin
            total = fpadd_pkg::INF_BITS;
        end

        if (norm_q.spec)
        begin
            sum_next = norm_q.spec_val;
        end
        else if (norm_q.zero)
        begin
            sum_next = 32'd0;
        end
        else
        begin
            sum_next = {norm_q.sign, total[30:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_bits = sum_reg;

endmodule

[rtl/fp32_adder_unit.sv]
// Top level of the single-precision adder: pipeline control and stages.
// Depends on fpadd_pkg, fpadd_front, fpadd_add and fpadd_round.

// IEEE-754 binary32 adder with round to nearest even, subnormal support,
// canonical quiet NaN 0x7FC00000 for NaN operands and opposite infinities,
// +0 for an exact zero sum and saturation to infinity on overflow. It is a
// five-stage pipeline (decode, align, add, leading-one search, normalize and
// round), so a result is presented on the output from the last stage register
// once its transaction has passed through every stage; one operand pair can
// be accepted every cycle unless the pipeline is full and the output stalled. Each stage holds when
// the stage after it is full and stalled, so empty stages still fill while
// the output waits, and no transaction is lost or repeated.
module fp32_adder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sum_bits
);

    fpadd_pkg::stage_en_t en;
    fpadd_pkg::align_t    align_q;
    fpadd_pkg::norm_t     norm_q;

    logic [5:1] valid_reg;
    logic [5:1] valid_next;

    // A stage advances when it is empty or the next stage advances.
    always_comb
    begin
        en.en5 = !valid_reg[5] || out_ready;
        en.en4 = !valid_reg[4] || en.en5;
        en.en3 = !valid_reg[3] || en.en4;
        en.en2 = !valid_reg[2] || en.en3;
        en.en1 = !valid_reg[1] || en.en2;
        valid_next[1] = en.en1 ? in_valid     : valid_reg[1];
        valid_next[2] = en.en2 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = en.en3 ? valid_reg[2] : valid_reg[3];
        valid_next[4] = en.en4 ? valid_reg[3] : valid_reg[4];
        valid_next[5] = en.en5 ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en.en1;
    assign out_valid = valid_reg[5];

    fpadd_front u_front (
        .clk       (clk),
        .en1       (en.en1),
        .en2       (en.en2),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .align_q   (align_q)
    );

    fpadd_add u_add (
        .clk     (clk),
        .en3     (en.en3),
        .en4     (en.en4),
        .align_q (align_q),
        .norm_q  (norm_q)
    );

    fpadd_round u_round (
        .clk      (clk),
        .en5      (en.en5),
        .norm_q   (norm_q),
        .sum_bits (sum_bits)
    );

`ifndef SYNTH
    // An accepted transaction occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[1])
        else $error("accepted transaction did not enter stage 1");

    // A full stage that advances hands its transaction to the next stage.
    a_stage4_moves: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] && en.en4 |=> valid_reg[5])
        else $error("stage 4 transaction lost");

    // A full stage 1 never accepts while stage 2 is blocked.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !en.en2 |-> !in_ready)
        else $error("stage 1 overwritten while stalled");

    // An all-ones exponent on the output is infinity or the canonical NaN.
    a_special_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sum_bits[30:23] == 8'hFF) |->
            (sum_bits[22:0] == 23'd0) || (sum_bits == fpadd_pkg::QNAN_BITS))
        else $error("malformed infinity or NaN on output");
`endif

endmodule

[tb/tb_fp32_adder_unit.sv]
// Testbench for fp32_adder_unit: drives operand pairs over a valid/ready channel.
// Depends on fpadd_pkg and the fp32_adder_unit RTL; predicts each sum internally.
`timescale 1ns / 1ps

module tb_fp32_adder_unit;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] sum_bits;

    logic [31:0] sum_queue[$];
    int          mismatch_count;
    int          hold_cycles;
    bit          stim_done;

    fp32_adder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_bits  (sum_bits)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Computes the rounded binary32 sum of two bit patterns.
    function automatic logic [31:0] fp_sum(input logic [31:0] a, input logic [31:0] b);
        logic        sa, sb, smx, smn, sgn, subn;
        logic [7:0]  ea, eb, emx, emn;
        logic [23:0] ma, mb, mmx, mmn;
        int          dshift, top, shamt, lim;
        longint      vbig, vsmall, s;
        logic [63:0] mag, r, e, total;
        logic        guard, lsb;
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        ma = {1'b0, a[22:0]};
        mb = {1'b0, b[22:0]};
        if (ea == 8'hFF || eb == 8'hFF)
        begin
            if ((ea == 8'hFF && ma != 0) || (eb == 8'hFF && mb != 0))
                return fpadd_pkg::QNAN_BITS;
            if (ea == 8'hFF && eb == 8'hFF && sa != sb)
                return fpadd_pkg::QNAN_BITS;
            if (ea == 8'hFF)
                return {sa, 31'b0} | fpadd_pkg::INF_BITS;
            return {sb, 31'b0} | fpadd_pkg::INF_BITS;
        end
        ma = (ea != 0) ? (ma | 24'h800000) : (ma << 1);
        mb = (eb != 0) ? (mb | 24'h800000) : (mb << 1);
        emx = ea; emn = eb; mmx = ma; mmn = mb; smx = sa; smn = sb;
        if (eb > ea)
        begin
            emx = eb; emn = ea; mmx = mb; mmn = ma; smx = sb; smn = sa;
        end
        dshift = emx - emn;
        if (dshift > 25)
            dshift = 25;
        vbig = longint'(mmx) <<< 25;
        vsmall = longint'(mmn) <<< (25 - dshift);
        if (smx)
            vbig = -vbig;
        if (smn)
            vsmall = -vsmall;
        s = vbig + vsmall;
        if (s == 0)
            return 32'h0;
        sgn = (s < 0);
        mag = sgn ? 64'(-s) : 64'(s);
        top = 0;
        for (int i = 0; i <= 50; i++)
            if (mag[i])
                top = i;
        shamt = 50 - top;
        lim = emx + 1;
        subn = shamt > lim;
        if (subn)
            shamt = lim;
        mag = mag << shamt;
        guard = mag[26];
        lsb = mag[27];
        r = (mag >> 27) + ((guard && ((mag & 64'h3FFFFFF) != 0 || lsb)) ? 1 : 0);
        e = subn ? 64'd0 : 64'(emx + top - 49);
        total = (e << 23) + r;
        if (total >= 64'(fpadd_pkg::INF_BITS))
            total = 64'(fpadd_pkg::INF_BITS);
        return {sgn, total[30:0]};
    endfunction

    task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
        $display("%0t: sum_bits mismatch: got %08h expected %08h", $time, got, want);
        mismatch_count++;
    endtask

    // Sends one operand pair and records its expected sum on acceptance.
    // Valid stays high after an acceptance until the next pair or an idle gap.
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sum_queue.push_back(fp_sum(a, b));
        @(negedge clk);
    endtask

    // Result checker: compares each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sum_queue.size() == 0)
            begin
                report_mismatch(sum_bits, 'x);
            end
            else
            begin
                logic [31:0] want;
                want = sum_queue.pop_front();
                if (sum_bits !== want)
                    report_mismatch(sum_bits, want);
            end
        end
    end

    // Receiver: random stalls, with an optional long hold-off.
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (out_ready && !(out_valid))
                out_ready <= 1'b1;
            else if (!out_ready || out_valid)
            begin
                wait_n = stim_done ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0)
                    wait_n = 0;
                if (wait_n == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (wait_n) @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'($urandom_range(0, 3));
            3: v[30:23] = 8'($urandom_range(252, 254));
            4: v[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [31:0] vals[12];
        vals = '{32'h0, 32'h80000000, 32'h00000001, 32'h007FFFFF, 32'h00800000,
                 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F800000, 32'hFF800000,
                 32'h7FC00000, 32'hFF800001, 32'h3F800000};
        send_pair(32'h0, 32'h0, 0);
        send_pair(32'h80000000, 32'h80000000, 0);
        send_pair(32'h7F800000, 32'hFF800000, 0);
        send_pair(32'h7F800000, 32'h7F800000, 0);
        send_pair(32'hFF800000, 32'h3F800000, 0);
        send_pair(32'h7F800001, 32'h0, 0);
        send_pair(32'h3F800000, 32'h7FFFFFFF, 0);
        send_pair(32'h7F7FFFFF, 32'h7F7FFFFF, 0);
        send_pair(32'hFF7FFFFF, 32'hFF7FFFFF, 0);
        send_pair(32'h007FFFFF, 32'h00000001, 0);
        send_pair(32'h3F800000, 32'hBF800000, 0);
        send_pair(32'h3F800000, 32'h33800000, 0);
        send_pair(32'h3F800001, 32'h33800000, 0);
        send_pair(32'h3F7FFFFF, 32'h33800000, 0);
        send_pair(32'h7F000000, 32'h00000001, 1);
        send_pair(32'h00800000, 32'h80000001, 1);
        for (int i = 0; i < 8; i++)
            send_pair(vals[$urandom_range(0, 11)], vals[$urandom_range(0, 11)], 1);
    endtask

    task automatic test_random(input int count);
        logic [31:0] a, b;
        for (int i = 0; i < count; i++)
        begin
            a = rand_float();
            b = $urandom_range(0, 1) ? rand_float() : (a ^ 32'h80000000) + $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                b[30:23] = a[30:23] - 8'($urandom_range(0, 30));
            send_pair(a, b, $urandom_range(0, 4) != 0);
        end
    endtask

    // Long output stall while the sender keeps pushing back-to-back.
    task automatic test_backpressure();
        hold_cycles = 40;
        for (int i = 0; i < 30; i++)
            send_pair(rand_float(), rand_float(), 0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operand_a = '0;
        operand_b = '0;
        mismatch_count = 0;
        hold_cycles = 0;
        stim_done = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(380);
        test_backpressure();
        test_random(380);
        stim_done = 1;
        in_valid <= 1'b0;
        while (sum_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && sum_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
